// ----- src/pns_pkg.sv -----
// Shared types, widths and codes for the pitch note segmenter.
`timescale 1ns / 1ps

package pns_pkg;

   // Field widths
   localparam int PITCH_W  = 16;
   localparam int FRAMES_W = 16;
   localparam int BIN_W    = 8;
   localparam int VEL_W    = 15;
   localparam int MINF_W   = 6;
   localparam int WLEN_W   = 6;
   localparam int COUNT_W  = 16;

   // Default sizes
   localparam int HIST_BINS_DEF  = 150;
   localparam int WINDOW_MAX_DEF = 33;

   // Register reset values
   localparam logic [VEL_W-1:0]  VEL_RESET  = 15'd26;
   localparam logic [MINF_W-1:0] MINF_RESET = 6'd25;
   localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd11;

   // APB port
   localparam int APB_ADDR_W = 4;
   localparam int APB_DATA_W = 32;
   localparam int REG_IW     = 2;
   localparam logic [REG_IW-1:0] REG_VEL  = 2'd0;
   localparam logic [REG_IW-1:0] REG_MINF = 2'd1;
   localparam logic [REG_IW-1:0] REG_WLEN = 2'd2;

   // Histogram operations
   localparam logic [1:0] HOP_INC   = 2'd0;
   localparam logic [1:0] HOP_SCAN  = 2'd1;
   localparam logic [1:0] HOP_CLEAR = 2'd2;

   typedef struct packed {
      logic               start;
      logic [1:0]         op;
      logic [BIN_W-1:0]   bin;
   } hist_cmd_type;

   typedef struct packed {
      logic               done;
      logic [BIN_W-1:0]   best;
   } hist_sts_type;

   typedef struct packed {
      logic               done;
      logic [PITCH_W-1:0] median;
   } med_sts_type;

endpackage

// ----- src/pns_req_if.sv -----
// Request channel carrying one pitch frame.
`timescale 1ns / 1ps

interface pns_req_if;
   import pns_pkg::*;

   logic               valid;
   logic               ready;
   logic [PITCH_W-1:0] pitch_in;

   modport source (output valid, output pitch_in, input ready);
   modport sink   (input valid, input pitch_in, output ready);
endinterface

// ----- src/pns_rsp_if.sv -----
// Result channel carrying the smoothed pitch and note report.
`timescale 1ns / 1ps

interface pns_rsp_if;
   import pns_pkg::*;

   logic                valid;
   logic                ready;
   logic [PITCH_W-1:0]  smoothed_pitch;
   logic                recording;
   logic                note_done;
   logic [BIN_W-1:0]    note_pitch;
   logic [FRAMES_W-1:0] note_frames;

   modport source (output valid, output smoothed_pitch, output recording, output note_done,
                   output note_pitch, output note_frames, input ready);
   modport sink   (input valid, input smoothed_pitch, input recording, input note_done,
                   input note_pitch, input note_frames, output ready);
endinterface

// ----- src/pns_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module pns_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH)-1:0]         waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH)-1:0]         raddr,
   output logic [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

// ----- src/pns_median.sv -----
// Pitch history memory and bit-serial rank search for the running median.
`timescale 1ns / 1ps

module pns_median #(
   parameter int WINDOW_MAX = pns_pkg::WINDOW_MAX_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pns_pkg::PITCH_W-1:0]  pitch,
   input  logic [pns_pkg::WLEN_W-1:0]   win_len,
   output pns_pkg::med_sts_type         sts
);
   import pns_pkg::*;

   localparam int WIN_AW = $clog2(WINDOW_MAX);
   localparam int BIT_AW = $clog2(PITCH_W);
   localparam logic [WIN_AW-1:0] LAST_ADDR = WIN_AW'(WINDOW_MAX - 1);
   localparam logic [WLEN_W-1:0] LEN_MIN   = WLEN_W'(3);
   localparam logic [WLEN_W-1:0] LEN_MAX   = WLEN_W'(WINDOW_MAX);

   localparam logic [2:0] M_IDLE  = 3'd0;
   localparam logic [2:0] M_WRITE = 3'd1;
   localparam logic [2:0] M_PASS  = 3'd2;
   localparam logic [2:0] M_EVAL  = 3'd3;

   logic [2:0]            state_ff, state_in;
   logic [WIN_AW-1:0]     pos_ff, pos_in;
   logic [WINDOW_MAX-1:0] wvalid_ff, wvalid_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  done_ff, done_in;

   logic [PITCH_W-1:0]    pitch_ff, pitch_in;
   logic [WIN_AW-1:0]     first_ff, first_in;
   logic [WIN_AW-1:0]     addr_ff, addr_in;
   logic [WLEN_W-1:0]     n_ff, n_in;
   logic [WLEN_W-1:0]     k_ff, k_in;
   logic [WLEN_W-1:0]     cnt_ff, cnt_in;
   logic [WLEN_W-1:0]     iss_ff, iss_in;
   logic [BIT_AW-1:0]     bit_ff, bit_in;
   logic [PITCH_W-1:0]    res_ff, res_in;
   logic                  rd_ok_ff, rd_ok_in;

   logic                  ram_we;
   logic [PITCH_W-1:0]    rdata;
   logic [PITCH_W-1:0]    entry;
   logic [PITCH_W-1:0]    hi_mask;
   logic                  match;
   logic [WLEN_W-1:0]     eff_len;

   pns_ram #(.WIDTH(PITCH_W), .DEPTH(WINDOW_MAX)) u_win_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (pos_ff),
      .wdata (pitch_ff),
      .raddr (addr_ff),
      .rdata (rdata)
   );

   // Clamp window length to the supported range
   always_comb begin
      if (win_len < LEN_MIN) begin
         eff_len = LEN_MIN;
      end else if (win_len > LEN_MAX) begin
         eff_len = LEN_MAX;
      end else begin
         eff_len = win_len;
      end
   end

   // Entry read back this cycle; slots never written read as zero
   assign entry   = rd_ok_ff ? rdata : '0;
   assign hi_mask = PITCH_W'({PITCH_W{1'b1}} << ({1'b0, bit_ff} + 5'd1));
   assign match   = (((entry ^ res_ff) & hi_mask) == '0) && !entry[bit_ff];

   // Sequencer: write frame, then one counting pass per result bit
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      wvalid_in = wvalid_ff;
      rd_vld_in = 1'b0;
      done_in   = 1'b0;
      pitch_in  = pitch_ff;
      first_in  = first_ff;
      addr_in   = addr_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      iss_in    = iss_ff;
      bit_in    = bit_ff;
      res_in    = res_ff;
      rd_ok_in  = rd_ok_ff;
      ram_we    = 1'b0;

      unique case (state_ff)
         M_IDLE: begin
            if (start) begin
               pitch_in = pitch;
               n_in     = eff_len;
               k_in     = eff_len >> 1;
               res_in   = '0;
               bit_in   = BIT_AW'(PITCH_W - 1);
               state_in = M_WRITE;
            end
         end
         M_WRITE: begin
            ram_we            = 1'b1;
            wvalid_in[pos_ff] = 1'b1;
            first_in          = pos_ff;
            addr_in           = pos_ff;
            pos_in            = (pos_ff == LAST_ADDR) ? '0 : pos_ff + 1'b1;
            iss_in            = '0;
            cnt_in            = '0;
            state_in          = M_PASS;
         end
         M_PASS: begin
            // issue one read a cycle, newest frame first
            if (iss_ff < n_ff) begin
               rd_vld_in = 1'b1;
               rd_ok_in  = wvalid_ff[addr_ff];
               addr_in   = (addr_ff == '0) ? LAST_ADDR : addr_ff - 1'b1;
               iss_in    = iss_ff + 1'b1;
            end
            if (rd_vld_ff && match) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (iss_ff == n_ff && !rd_vld_ff) begin
               state_in = M_EVAL;
            end
         end
         M_EVAL: begin
            // bit is one if fewer than k+1 entries lie below it
            if (k_ff >= cnt_ff) begin
               res_in[bit_ff] = 1'b1;
               k_in           = k_ff - cnt_ff;
            end
            if (bit_ff == '0) begin
               done_in  = 1'b1;
               state_in = M_IDLE;
            end else begin
               bit_in   = bit_ff - 1'b1;
               iss_in   = '0;
               cnt_in   = '0;
               addr_in  = first_ff;
               state_in = M_PASS;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= M_IDLE;
         pos_ff    <= '0;
         wvalid_ff <= '0;
         rd_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         wvalid_ff <= wvalid_in;
         rd_vld_ff <= rd_vld_in;
         done_ff   <= done_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      pitch_ff <= pitch_in;
      first_ff <= first_in;
      addr_ff  <= addr_in;
      n_ff     <= n_in;
      k_ff     <= k_in;
      cnt_ff   <= cnt_in;
      iss_ff   <= iss_in;
      bit_ff   <= bit_in;
      res_ff   <= res_in;
      rd_ok_ff <= rd_ok_in;
   end

   assign sts.done   = done_ff;
   assign sts.median = res_ff;
endmodule

// ----- src/pns_hist.sv -----
// Pitch histogram memory: saturating increment, peak scan and clear.
`timescale 1ns / 1ps

module pns_hist #(
   parameter int HIST_BINS = pns_pkg::HIST_BINS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pns_pkg::hist_cmd_type  cmd,
   output pns_pkg::hist_sts_type  sts
);
   import pns_pkg::*;

   localparam int HIST_AW = $clog2(HIST_BINS);
   localparam int HIST_CW = $clog2(HIST_BINS + 1);
   localparam logic [HIST_CW-1:0] BINS_END  = HIST_CW'(HIST_BINS);
   localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};

   localparam logic [1:0] H_IDLE   = 2'd0;
   localparam logic [1:0] H_INC_RD = 2'd1;
   localparam logic [1:0] H_INC_WR = 2'd2;
   localparam logic [1:0] H_SCAN   = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [HIST_BINS-1:0] hvalid_ff, hvalid_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic                 done_ff, done_in;

   logic [HIST_AW-1:0]   addr_ff, addr_in;
   logic [HIST_CW-1:0]   iss_ff, iss_in;
   logic [HIST_AW-1:0]   rd_bin_ff, rd_bin_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic [HIST_AW-1:0]   best_ff, best_in;
   logic [COUNT_W-1:0]   top_ff, top_in;

   logic                 ram_we;
   logic [HIST_AW-1:0]   raddr;
   logic [COUNT_W-1:0]   rdata;
   logic [COUNT_W-1:0]   count;
   logic [COUNT_W-1:0]   count_inc;

   pns_ram #(.WIDTH(COUNT_W), .DEPTH(HIST_BINS)) u_hist_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata (count_inc),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign raddr     = (state_ff == H_SCAN) ? iss_ff[HIST_AW-1:0] : addr_ff;
   assign count     = rd_ok_ff ? rdata : '0;
   assign count_inc = (count == COUNT_TOP) ? count : count + 1'b1;

   always_comb begin
      state_in  = state_ff;
      hvalid_in = hvalid_ff;
      rd_vld_in = 1'b0;
      done_in   = 1'b0;
      addr_in   = addr_ff;
      iss_in    = iss_ff;
      rd_bin_in = rd_bin_ff;
      rd_ok_in  = rd_ok_ff;
      best_in   = best_ff;
      top_in    = top_ff;
      ram_we    = 1'b0;

      unique case (state_ff)
         H_IDLE: begin
            if (cmd.start) begin
               case (cmd.op)
                  HOP_INC: begin
                     addr_in  = cmd.bin[HIST_AW-1:0];
                     state_in = H_INC_RD;
                  end
                  HOP_SCAN: begin
                     iss_in   = HIST_CW'(1);
                     best_in  = '0;
                     top_in   = '0;
                     state_in = H_SCAN;
                  end
                  default: begin
                     hvalid_in = '0;
                     done_in   = 1'b1;
                  end
               endcase
            end
         end
         H_INC_RD: begin
            rd_ok_in = hvalid_ff[addr_ff];
            state_in = H_INC_WR;
         end
         H_INC_WR: begin
            ram_we             = 1'b1;
            hvalid_in[addr_ff] = 1'b1;
            done_in            = 1'b1;
            state_in           = H_IDLE;
         end
         H_SCAN: begin
            // one bin a cycle; strict compare keeps the lowest bin on ties
            if (iss_ff < BINS_END) begin
               rd_vld_in = 1'b1;
               rd_ok_in  = hvalid_ff[iss_ff[HIST_AW-1:0]];
               rd_bin_in = iss_ff[HIST_AW-1:0];
               iss_in    = iss_ff + 1'b1;
            end
            if (rd_vld_ff && count > top_ff) begin
               top_in  = count;
               best_in = rd_bin_ff;
            end
            if (iss_ff == BINS_END && !rd_vld_ff) begin
               hvalid_in = '0;
               done_in   = 1'b1;
               state_in  = H_IDLE;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= H_IDLE;
         hvalid_ff <= '0;
         rd_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hvalid_ff <= hvalid_in;
         rd_vld_ff <= rd_vld_in;
         done_ff   <= done_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      iss_ff    <= iss_in;
      rd_bin_ff <= rd_bin_in;
      rd_ok_ff  <= rd_ok_in;
      best_ff   <= best_in;
      top_ff    <= top_in;
   end

   assign sts.done = done_ff;
   assign sts.best = BIN_W'(best_ff);
endmodule

// ----- src/pitch_note_segmenter.sv -----
// Top level of the pitch note segmenter: registers, frame sequencer, result stage.
`timescale 1ns / 1ps

// Takes one pitch frame (unsigned 8.8) per request and returns one result: the
// median of the last window_len frames, whether the frame continues a note, and,
// when a note ends, its length and most common integer pitch. Frames are handled
// one at a time; the window length is clamped to 3..WINDOW_MAX. The median is
// found one result bit per pass over the history memory, which has a single read
// port. A frame that counts a bin in range then does a read-modify-write of the
// histogram. A frame that ends a run too short to report then clears the
// histogram, and one that closes a note long enough to report scans it. A new
// request is taken while the previous result still waits in the output register;
// a frame that finishes while that register is still full waits until the
// receiver takes the older result. No clearing pass follows reset; both
// memories carry valid bits. Registers sit on the APB port at 0x0
// (vel_threshold), 0x4 (min_frames) and 0x8 (window_len); the user must see
// that they are written only while the block is idle, as the block itself
// does not enforce it.
module pitch_note_segmenter #(
   parameter int HIST_BINS  = pns_pkg::HIST_BINS_DEF,
   parameter int WINDOW_MAX = pns_pkg::WINDOW_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   pns_req_if.sink                         req_chan,
   pns_rsp_if.source                       rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pns_pkg::APB_ADDR_W-1:0]  paddr,
   input  logic [pns_pkg::APB_DATA_W-1:0]  pwdata,
   output logic [pns_pkg::APB_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import pns_pkg::*;

   localparam logic [BIN_W:0]      BINS_LIM   = (BIN_W + 1)'(HIST_BINS);
   localparam logic [FRAMES_W-1:0] FRAMES_TOP = {FRAMES_W{1'b1}};

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_MED  = 2'd1;
   localparam logic [1:0] T_HIST = 2'd2;
   localparam logic [1:0] T_OUT  = 2'd3;

   // Configuration registers
   logic [VEL_W-1:0]    vel_ff;
   logic [MINF_W-1:0]   minf_ff;
   logic [WLEN_W-1:0]   wlen_ff;
   logic                cfg_we;
   logic [REG_IW-1:0]   reg_idx;

   // Sequencer
   logic [1:0]          state_ff, state_in;
   logic [PITCH_W-1:0]  prev_ff, prev_in;
   logic [FRAMES_W-1:0] run_ff, run_in;
   hist_cmd_type        hcmd_ff, hcmd_in;

   // Result being built
   logic [PITCH_W-1:0]  med_ff, med_in;
   logic                rec_ff, rec_in;
   logic                ndone_ff, ndone_in;
   logic [BIN_W-1:0]    npitch_ff, npitch_in;
   logic [FRAMES_W-1:0] nframes_ff, nframes_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PITCH_W-1:0]  rsp_med_ff;
   logic                rsp_rec_ff;
   logic                rsp_done_ff;
   logic [BIN_W-1:0]    rsp_pitch_ff;
   logic [FRAMES_W-1:0] rsp_frames_ff;
   logic                rsp_load;

   logic                req_take;
   med_sts_type         med_sts;
   hist_sts_type        hist_sts;
   logic [PITCH_W-1:0]  vel;
   logic [BIN_W-1:0]    ipart;

   pns_median #(.WINDOW_MAX(WINDOW_MAX)) u_median (
      .clock   (clock),
      .reset   (reset),
      .start   (req_take),
      .pitch   (req_chan.pitch_in),
      .win_len (wlen_ff),
      .sts     (med_sts)
   );

   pns_hist #(.HIST_BINS(HIST_BINS)) u_hist (
      .clock (clock),
      .reset (reset),
      .cmd   (hcmd_ff),
      .sts   (hist_sts)
   );

   // APB register port
   assign pready  = 1'b1;
   assign reg_idx = paddr[REG_IW+1:2];
   assign cfg_we  = psel && penable && pwrite;

   always_comb begin
      unique case (reg_idx)
         REG_VEL:  prdata = APB_DATA_W'(vel_ff);
         REG_MINF: prdata = APB_DATA_W'(minf_ff);
         REG_WLEN: prdata = APB_DATA_W'(wlen_ff);
         default:  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff  <= VEL_RESET;
         minf_ff <= MINF_RESET;
         wlen_ff <= WLEN_RESET;
      end else if (cfg_we) begin
         case (reg_idx)
            REG_VEL:  vel_ff  <= pwdata[VEL_W-1:0];
            REG_MINF: minf_ff <= pwdata[MINF_W-1:0];
            REG_WLEN: wlen_ff <= pwdata[WLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Request handshake
   assign req_chan.ready = (state_ff == T_IDLE);
   assign req_take       = req_chan.valid && (state_ff == T_IDLE);

   // Velocity of the new median
   assign vel   = (med_sts.median >= prev_ff) ? med_sts.median - prev_ff
                                              : prev_ff - med_sts.median;
   assign ipart = med_sts.median[PITCH_W-1:PITCH_W-BIN_W];

   assign rsp_load = (state_ff == T_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // Frame sequencer
   always_comb begin
      state_in   = state_ff;
      prev_in    = prev_ff;
      run_in     = run_ff;
      hcmd_in    = '0;
      med_in     = med_ff;
      rec_in     = rec_ff;
      ndone_in   = ndone_ff;
      npitch_in  = npitch_ff;
      nframes_in = nframes_ff;

      unique case (state_ff)
         T_IDLE: begin
            if (req_take) begin
               state_in = T_MED;
            end
         end
         T_MED: begin
            if (med_sts.done) begin
               med_in     = med_sts.median;
               prev_in    = med_sts.median;
               ndone_in   = 1'b0;
               npitch_in  = '0;
               nframes_in = '0;
               hcmd_in.bin = ipart;
               if (vel < {1'b0, vel_ff}) begin
                  // frame continues the run
                  rec_in = 1'b1;
                  run_in = (run_ff == FRAMES_TOP) ? run_ff : run_ff + 1'b1;
                  if (ipart != '0 && {1'b0, ipart} < BINS_LIM) begin
                     hcmd_in.start = 1'b1;
                     hcmd_in.op    = HOP_INC;
                     state_in      = T_HIST;
                  end else begin
                     state_in = T_OUT;
                  end
               end else begin
                  // run ends; report it if long enough, then clear
                  rec_in        = 1'b0;
                  run_in        = '0;
                  hcmd_in.start = 1'b1;
                  state_in      = T_HIST;
                  if (run_ff > FRAMES_W'(minf_ff)) begin
                     ndone_in   = 1'b1;
                     nframes_in = run_ff;
                     hcmd_in.op = HOP_SCAN;
                  end else begin
                     hcmd_in.op = HOP_CLEAR;
                  end
               end
            end
         end
         T_HIST: begin
            if (hist_sts.done) begin
               npitch_in = ndone_ff ? hist_sts.best : '0;
               state_in  = T_OUT;
            end
         end
         T_OUT: begin
            if (rsp_load) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         prev_ff      <= '0;
         run_ff       <= '0;
         hcmd_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         run_ff       <= run_in;
         hcmd_ff      <= hcmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      med_ff     <= med_in;
      rec_ff     <= rec_in;
      ndone_ff   <= ndone_in;
      npitch_ff  <= npitch_in;
      nframes_ff <= nframes_in;
      if (rsp_load) begin
         rsp_med_ff    <= med_ff;
         rsp_rec_ff    <= rec_ff;
         rsp_done_ff   <= ndone_ff;
         rsp_pitch_ff  <= npitch_ff;
         rsp_frames_ff <= nframes_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.smoothed_pitch = rsp_med_ff;
   assign rsp_chan.recording      = rsp_rec_ff;
   assign rsp_chan.note_done      = rsp_done_ff;
   assign rsp_chan.note_pitch     = rsp_pitch_ff;
   assign rsp_chan.note_frames    = rsp_frames_ff;
endmodule
